@@ rtl/ezr_pkg.sv @@
// Shared types and constants for the escape zero-run decoder.
`default_nettype none
package ezr_pkg;

  localparam int CountBits = 24;
  localparam int CapBits   = 24;
  localparam int RoomBits  = (CountBits > CapBits) ? CountBits : CapBits;
  localparam int LenBits   = 16;
  localparam int TotalBits = 24;
  localparam int FifoDepth = 2;
  localparam int PtrBits   = $clog2(FifoDepth);
  localparam int FillBits  = $clog2(FifoDepth + 1);

  localparam logic [7:0] CodeEnd     = 8'h00;
  localparam logic [7:0] CodeEscape  = 8'h01;
  localparam logic [LenBits-1:0] LongRunBias = LenBits'(8'h80);

  typedef enum logic [1:0] {
    PH_ESC  = 2'd0,
    PH_BYTE = 2'd1,
    PH_CODE = 2'd2,
    PH_LOW  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_START = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]           run_value;
    logic [LenBits-1:0]   run_length;
    logic                 stream_end;
    status_e              status;
    logic [TotalBits-1:0] total_written;
  } out_beat_t;

  typedef struct packed {
    cmd_e               kind;
    logic [7:0]         value;
    logic [LenBits-1:0] len;
    logic               last;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/ezr_front.sv @@
// Front end: parses escape codes and turns each input beat into a command.
`default_nettype none
module ezr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ezr_pkg::in_beat_t in_beat_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output ezr_pkg::cmd_t        q_cmd_o
);
  import ezr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] esc_q, esc_d;
  logic [6:0] hi_q, hi_d;
  logic       accept;
  logic [7:0] b;

  assign b          = in_beat_i.in_byte;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    hi_d    = hi_q;
    case (phase_q)
      PH_ESC: begin
        esc_d   = b;
        hi_d    = '0;
        phase_d = PH_BYTE;
      end
      PH_BYTE: begin
        phase_d = (b == esc_q) ? PH_CODE : PH_BYTE;
      end
      PH_CODE: begin
        if (b == CodeEnd) begin
          phase_d = PH_ESC;
        end else if (b[7]) begin
          hi_d    = b[6:0];
          phase_d = PH_LOW;
        end else begin
          phase_d = PH_BYTE;
        end
      end
      PH_LOW: begin
        phase_d = PH_BYTE;
      end
      default: begin
        phase_d = PH_ESC;
      end
    endcase
    if (in_beat_i.in_last) begin
      phase_d = PH_ESC;
    end
  end

  always_comb begin
    q_cmd_o.kind  = CMD_NOP;
    q_cmd_o.value = '0;
    q_cmd_o.len   = '0;
    q_cmd_o.last  = in_beat_i.in_last;
    case (phase_q)
      PH_ESC: begin
        q_cmd_o.kind = CMD_START;
      end
      PH_BYTE: begin
        if (b != esc_q) begin
          q_cmd_o.kind  = CMD_RUN;
          q_cmd_o.value = b;
          q_cmd_o.len   = LenBits'(1);
        end
      end
      PH_CODE: begin
        if (b == CodeEnd) begin
          q_cmd_o.kind = CMD_END;
        end else if (b == CodeEscape) begin
          q_cmd_o.kind  = CMD_RUN;
          q_cmd_o.value = esc_q;
          q_cmd_o.len   = LenBits'(1);
        end else if (!b[7]) begin
          q_cmd_o.kind = CMD_RUN;
          q_cmd_o.len  = LenBits'(b);
        end
      end
      PH_LOW: begin
        q_cmd_o.kind = CMD_RUN;
        q_cmd_o.len  = LenBits'({hi_q, b}) + LongRunBias;
      end
      default: begin
        q_cmd_o.kind = CMD_NOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ESC;
      esc_q   <= '0;
      hi_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      hi_q    <= hi_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ezr_fifo.sv @@
// Command queue between front and back end.
`default_nettype none
module ezr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ezr_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output ezr_pkg::cmd_t      head_o
);
  import ezr_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillBits-1:0] fill_q;
  logic                do_pop;

  assign full_o  = (fill_q == FillBits'(FifoDepth));
  assign valid_o = (fill_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (push_i && !do_pop) begin
        fill_q <= fill_q + FillBits'(1);
      end else if (!push_i && do_pop) begin
        fill_q <= fill_q - FillBits'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/ezr_back.sv @@
// Back end: counts decoded bytes, checks capacity and drives the result register.
`default_nettype none
module ezr_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ezr_pkg::CapBits-1:0]     cfg_wdata_i,
  input  wire logic                            q_valid_i,
  input  wire ezr_pkg::cmd_t                   q_head_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output ezr_pkg::out_beat_t                   out_beat_o
);
  import ezr_pkg::*;

  logic [CapBits-1:0]   cap_q;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 discard_q, discard_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic                 take;
  logic                 emit;
  logic [RoomBits-1:0]  cap_ext, cnt_ext, room, len_ext, add_len, cnt_sum;
  logic                 over;

  assign take    = !out_valid_q || !out_stall_i;
  assign q_pop_o = take && q_valid_i;

  assign cap_ext = RoomBits'(cap_q);
  assign cnt_ext = RoomBits'(cnt_q);
  assign room    = (cap_ext > cnt_ext) ? cap_ext - cnt_ext : '0;
  assign len_ext = RoomBits'(q_head_i.len);
  assign over    = len_ext > room;
  assign add_len = over ? room : len_ext;
  assign cnt_sum = cnt_ext + add_len;

  always_comb begin
    cnt_d     = cnt_q;
    discard_d = discard_q;
    emit      = 1'b0;
    out_d     = out_q;
    if (discard_q) begin
      if (q_head_i.last) begin
        discard_d = 1'b0;
      end
    end else begin
      case (q_head_i.kind)
        CMD_START: begin
          cnt_d = '0;
          if (q_head_i.last) begin
            emit                = 1'b1;
            out_d.run_value     = '0;
            out_d.run_length    = '0;
            out_d.stream_end    = 1'b1;
            out_d.status        = ST_TRUNCATED;
            out_d.total_written = '0;
          end
        end
        CMD_NOP: begin
          if (q_head_i.last) begin
            emit                = 1'b1;
            out_d.run_value     = '0;
            out_d.run_length    = '0;
            out_d.stream_end    = 1'b1;
            out_d.status        = ST_TRUNCATED;
            out_d.total_written = TotalBits'(cnt_q);
          end
        end
        CMD_END: begin
          emit                = 1'b1;
          out_d.run_value     = '0;
          out_d.run_length    = '0;
          out_d.stream_end    = 1'b1;
          out_d.status        = ST_OK;
          out_d.total_written = TotalBits'(cnt_q);
        end
        CMD_RUN: begin
          emit                = 1'b1;
          cnt_d               = CountBits'(cnt_sum);
          out_d.run_value     = q_head_i.value;
          out_d.run_length    = LenBits'(add_len);
          out_d.total_written = TotalBits'(CountBits'(cnt_sum));
          if (over) begin
            out_d.stream_end = 1'b1;
            out_d.status     = ST_OVERFLOW;
            discard_d        = !q_head_i.last;
          end else if (q_head_i.last) begin
            out_d.stream_end = 1'b1;
            out_d.status     = ST_TRUNCATED;
          end else begin
            out_d.stream_end = 1'b0;
            out_d.status     = ST_OK;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = q_valid_i && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '1;
      cnt_q       <= '0;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        cnt_q     <= cnt_d;
        discard_q <= discard_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_open_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.stream_end |-> out_q.status == ST_OK)
    else $error("open-stream beat carries an error status");

  a_discard_after_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(discard_q) |-> out_valid_q && out_q.status == ST_OVERFLOW)
    else $error("discard entered without an overflow beat");

  a_end_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.stream_end && out_q.status == ST_OK |-> out_q.run_length == '0)
    else $error("normal end beat carries a run");

endmodule
`default_nettype wire

@@ rtl/escape_zero_run_decoder.sv @@
// Top level of the escape zero-run decoder: front end, command queue, back end.
//
//   channel  direction  handshake                 beat
//   in       input      in_valid_i / in_stall_o    in_beat_i  (in_byte, in_last)
//   out      output     out_valid_o / out_stall_i  out_beat_o (run descriptor, status)
//   cfg      input      cfg_we_i                   cfg_wdata_i (out_capacity)
//
// One input beat per cycle while in_stall_o is low; a result passes through the
// command queue, then the result register. The front parses escape codes, a two-entry
// queue holds commands, and the back does the capacity compare and byte count into the
// result register. Reset returns to the escape phase with out_capacity at its maximum.
// in_stall_o rises only when the queue is full, which needs out_stall_i held.
`default_nettype none
module escape_zero_run_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ezr_pkg::CapBits-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire ezr_pkg::in_beat_t           in_beat_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output ezr_pkg::out_beat_t               out_beat_o
);
  import ezr_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  ezr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  ezr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  ezr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for escape_zero_run_decoder with directed, pressure and random streams.
module tb_top;
  import ezr_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CapBits-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_beat_t            in_beat_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_beat_t           out_beat_o;

  escape_zero_run_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("FAIL escape_zero_run_decoder");
    $finish;
  end

  // Decoder state mirror
  logic [CapBits-1:0]   cap_q = 24'hFFFFFF;
  phase_e               ph = PH_ESC;
  logic [7:0]           esc_val = 8'h00;
  logic [6:0]           hi7 = 7'h00;
  logic [TotalBits-1:0] wcount = '0;
  bit                   disc = 1'b0;

  out_beat_t pending_runs[$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b1;
  int        hold_left = 0;
  int        pattern_left = 0;
  int        stall_pct = 0;

  function automatic void queue_run(logic [7:0] v, logic [LenBits-1:0] len, bit fin,
                                    status_e st);
    out_beat_t r;
    r.run_value     = v;
    r.run_length    = len;
    r.stream_end    = fin;
    r.status        = st;
    r.total_written = wcount;
    pending_runs.push_back(r);
  endfunction

  function automatic void end_truncated();
    queue_run(8'h00, '0, 1'b1, ST_TRUNCATED);
    ph = PH_ESC;
  endfunction

  function automatic void take_run(logic [7:0] v, int unsigned len, bit last);
    int unsigned room;
    room = (cap_q > wcount) ? int'(cap_q) - int'(wcount) : 0;
    if (len > room) begin
      wcount = wcount + room[TotalBits-1:0];
      queue_run(v, room[LenBits-1:0], 1'b1, ST_OVERFLOW);
      ph = PH_ESC;
      disc = !last;
    end else begin
      wcount = wcount + len[TotalBits-1:0];
      if (last) begin
        queue_run(v, len[LenBits-1:0], 1'b1, ST_TRUNCATED);
        ph = PH_ESC;
      end else begin
        queue_run(v, len[LenBits-1:0], 1'b0, ST_OK);
        ph = PH_BYTE;
      end
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, bit last);
    if (disc) begin
      if (last) begin
        disc = 1'b0;
        ph = PH_ESC;
      end
      return;
    end
    case (ph)
      PH_ESC: begin
        esc_val = b;
        wcount = '0;
        hi7 = '0;
        ph = PH_BYTE;
        if (last) end_truncated();
      end
      PH_BYTE: begin
        if (b != esc_val) begin
          take_run(b, 1, last);
        end else begin
          ph = PH_CODE;
          if (last) end_truncated();
        end
      end
      PH_CODE: begin
        if (b == CodeEnd) begin
          queue_run(8'h00, '0, 1'b1, ST_OK);
          ph = PH_ESC;
        end else if (b == CodeEscape) begin
          take_run(esc_val, 1, last);
        end else if (!b[7]) begin
          take_run(8'h00, int'(b), last);
        end else begin
          hi7 = b[6:0];
          ph = PH_LOW;
          if (last) end_truncated();
        end
      end
      default: begin
        take_run(8'h00, ((int'(hi7) << 8) | int'(b)) + 128, last);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected run descriptor: value %0d length %0d",
               out_beat_o.run_value, out_beat_o.run_length);
        mismatches++;
      end else begin
        want = pending_runs.pop_front();
        if (out_beat_o.run_value !== want.run_value) begin
          $error("run_value: expected %0d, got %0d", want.run_value, out_beat_o.run_value);
          mismatches++;
        end
        if (out_beat_o.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length,
                 out_beat_o.run_length);
          mismatches++;
        end
        if (out_beat_o.stream_end !== want.stream_end) begin
          $error("stream_end: expected %0d, got %0d", want.stream_end,
                 out_beat_o.stream_end);
          mismatches++;
        end
        if (out_beat_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_beat_o.status);
          mismatches++;
        end
        if (out_beat_o.total_written !== want.total_written) begin
          $error("total_written: expected %0d, got %0d", want.total_written,
                 out_beat_o.total_written);
          mismatches++;
        end
      end
    end
  end

  // Receiver: long hold-off on request, otherwise stall at a rate picked per stretch
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = 64;
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 20;
            3: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pattern_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_beat(logic [7:0] b, bit last);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_beat_i.in_byte <= b;
    in_beat_i.in_last <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    beats_sent++;
    decode_byte(b, last);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [CapBits-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_q = v;
  endtask

  task automatic send_stream();
    in_beat_t   s[$];
    in_beat_t   x;
    logic [7:0] esc;
    logic [7:0] b;
    int         cut;
    case ($urandom_range(0, 7))
      0: esc = 8'h00;
      1: esc = 8'h01;
      2: esc = 8'hFF;
      3: esc = 8'h80;
      default: esc = 8'($urandom);
    endcase
    x.in_last = 1'b0;
    x.in_byte = esc;
    s.push_back(x);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          do b = 8'($urandom); while (b == esc);
          x.in_byte = b;
          s.push_back(x);
        end
        5: begin
          x.in_byte = esc;
          s.push_back(x);
          x.in_byte = CodeEscape;
          s.push_back(x);
        end
        6, 7: begin
          x.in_byte = esc;
          s.push_back(x);
          x.in_byte = 8'($urandom_range(2, 127));
          s.push_back(x);
        end
        default: begin
          x.in_byte = esc;
          s.push_back(x);
          x.in_byte = 8'($urandom_range(128, 255));
          s.push_back(x);
          x.in_byte = 8'($urandom);
          s.push_back(x);
        end
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      x.in_byte = esc;
      s.push_back(x);
      x.in_byte = CodeEnd;
      x.in_last = 1'($urandom_range(0, 1));
      s.push_back(x);
    end else begin
      cut = $urandom_range(1, s.size());
      s = s[0:cut-1];
      s[cut-1].in_last = 1'b1;
    end
    foreach (s[i]) send_beat(s[i].in_byte, s[i].in_last);
  endtask

  task automatic test_basic_codes();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h01, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h02, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h7F, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h80, 1'b0); send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b1);
  endtask

  task automatic test_truncation();
    send_beat(8'hAB, 1'b1);
    send_beat(8'h20, 1'b0); send_beat(8'h20, 1'b1);
    send_beat(8'h30, 1'b0); send_beat(8'h30, 1'b0); send_beat(8'h85, 1'b1);
  endtask

  task automatic test_overflow();
    write_cap(24'd3);
    send_beat(8'h07, 1'b0);
    send_beat(8'h10, 1'b0);
    send_beat(8'h07, 1'b0); send_beat(8'h05, 1'b0);
    send_beat(8'h22, 1'b0);
    send_beat(8'h23, 1'b1);
  endtask

  task automatic test_cap_lowered();
    write_cap(24'hFFFFFF);
    send_beat(8'h40, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h40, 1'b0); send_beat(8'h90, 1'b0); send_beat(8'h00, 1'b0);
    write_cap(24'd0);
    send_beat(8'h42, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [7:0] b;
    write_cap(24'hFFFFFF);
    gaps_on = 1'b0;
    hold_left = 300;
    send_beat(8'h5A, 1'b0);
    repeat (80) begin
      do b = 8'($urandom); while (b == 8'h5A);
      send_beat(b, 1'b0);
    end
    send_beat(8'h5A, 1'b0);
    send_beat(CodeEnd, 1'b1);
    settle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    logic [CapBits-1:0] cap;
    int                 target;
    for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
      case (phase_idx)
        0: cap = 24'hFFFFFF;
        1: cap = CapBits'($urandom_range(0, 300));
        2: cap = CapBits'($urandom_range(300, 40000));
        3: cap = 24'd0;
        4: cap = CapBits'($urandom);
        default: cap = CapBits'($urandom_range(1, 3));
      endcase
      write_cap(cap);
      gaps_on = $urandom_range(0, 2) != 0;
      target = beats_sent + 230;
      while (beats_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 8)) send_beat(8'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          send_stream();
        end
        if ($urandom_range(0, 19) == 0) settle();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_codes();
    test_truncation();
    test_overflow();
    test_cap_lowered();
    test_backpressure();
    test_random();
    settle();
    if (mismatches == 0) begin
      $display("PASS escape_zero_run_decoder");
    end else begin
      $display("FAIL escape_zero_run_decoder");
    end
    $finish;
  end

endmodule
